[rtl/core/mcfce_pkg.sv]
`timescale 1ns / 1ps
package mcfce_pkg;

  localparam int CARD_ADDR_BITS = 19;
  localparam int ADDR_BITS      = 25;
  localparam int BLOCK_BITS     = 13;   // 8 KB erase block
  localparam int SECTOR_BITS    = 9;    // 512-byte read/program wrap
  localparam int PAGE_BITS      = 7;    // 128-byte page buffer

  localparam logic [7:0] OP_SIZE_ID      = 8'h00;
  localparam logic [7:0] OP_READ_ARRAY   = 8'h52;
  localparam logic [7:0] OP_SET_INT      = 8'h81;
  localparam logic [7:0] OP_READ_STATUS  = 8'h83;
  localparam logic [7:0] OP_READ_ID      = 8'h85;
  localparam logic [7:0] OP_CLEAR_STATUS = 8'h89;
  localparam logic [7:0] OP_SECTOR_ERASE = 8'hF1;
  localparam logic [7:0] OP_PAGE_PROGRAM = 8'hF2;
  localparam logic [7:0] OP_CHIP_ERASE   = 8'hF4;

  localparam logic [7:0] ST_BUSY      = 8'h80;
  localparam logic [7:0] ST_UNLOCKED  = 8'h40;
  localparam logic [7:0] ST_ERASE_ERR = 8'h10;
  localparam logic [7:0] ST_PROG_ERR  = 8'h08;
  localparam logic [7:0] ST_READY     = 8'h01;

  localparam logic [1:0] REG_DEVICE_ID  = 2'd0;
  localparam logic [1:0] REG_SIZE_ID    = 2'd1;
  localparam logic [1:0] REG_DONE_DELAY = 2'd2;

  typedef enum logic [1:0] {
    CMD_SELECT   = 2'd0,
    CMD_DESELECT = 2'd1,
    CMD_TRANSFER = 2'd2,
    CMD_TICK     = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
  } item_t;

  typedef enum logic [2:0] {
    EX_INIT,
    EX_IDLE,
    EX_RD_WAIT,
    EX_SWEEP,
    EX_PROG_RD,
    EX_PROG_WR
  } exec_state_t;

  typedef struct packed {
    logic clearing;
    logic idle;
  } exec_stat_t;

  typedef struct packed {
    logic [15:0] device_id;
    logic [31:0] size_id;
    logic [15:0] done_delay;
  } cfg_t;

endpackage

[rtl/core/memory_card_flash_command_engine.sv]
`timescale 1ns / 1ps
// Channel | Ports                                        | Handshake
// in      | in_command, in_data_in                       | start && !busy
// out     | out_data_out, out_status_out, out_interrupt_out | out_strobe, one cycle
// cfg     | psel penable pwrite paddr pwdata prdata pready   | APB, pready tied high
//
// Select, tick, byte transfers and deselects with nothing to do: the result is
// registered after accept; array reads add the registered array port (EX_RD_WAIT).
// Sector erase sweeps one 8 KB block, chip erase the whole 2^CARD_ADDR_BITS-byte array,
// page program a page buffer read, then an array write, per byte written, one array port.
// After reset the whole 2^CARD_ADDR_BITS-byte array is swept to 0xFF; words queue
// (two deep) during the sweep and busy rises once the queue is full.
// The receiver cannot stall: each result word stands one cycle under out_strobe.
module memory_card_flash_command_engine import mcfce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_data_in,
  output logic        out_strobe,
  output logic [7:0]  out_data_out,
  output logic [7:0]  out_status_out,
  output logic        out_interrupt_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg_r;
  logic       q_valid, pop;
  item_t      q_item;
  exec_stat_t ex_stat;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // config registers, word per 4 bytes; writes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_id  <= 16'hC221;
      cfg_r.size_id    <= 32'h0000_0080;
      cfg_r.done_delay <= 16'd5000;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_DEVICE_ID:  cfg_r.device_id  <= pwdata[15:0];
        REG_SIZE_ID:    cfg_r.size_id    <= pwdata;
        REG_DONE_DELAY: cfg_r.done_delay <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DEVICE_ID:  prdata = {16'd0, cfg_r.device_id};
      REG_SIZE_ID:    prdata = cfg_r.size_id;
      REG_DONE_DELAY: prdata = {16'd0, cfg_r.done_delay};
      default:        prdata = 32'd0;
    endcase
  end

  // front: accepts words into the queue
  mcfce_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .cmd     (in_command),
    .data    (in_data_in),
    .pop     (pop),
    .busy    (busy),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  // back: executes one word at a time against the array
  mcfce_exec u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .stat       (ex_stat),
    .out_strobe (out_strobe),
    .out_data   (out_data_out),
    .out_status (out_status_out),
    .out_int    (out_interrupt_out)
  );

  // no result while the array is being cleared after reset
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ex_stat.clearing |-> !out_strobe) else $error("result during clearing pass");

  // an idle back end with nothing queued gives no result next cycle
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_stat.idle && !q_valid) |=> !out_strobe) else $error("result without a word");

  // an accepted word is held in the queue
  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> q_valid) else $error("accepted word lost");

endmodule

[rtl/core/mcfce_front.sv]
`timescale 1ns / 1ps
module mcfce_front import mcfce_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] cmd,
  input  logic [7:0] data,
  input  logic       pop,
  output logic       busy,
  output logic       q_valid,
  output item_t      q_item
);

  // two-word queue
  item_t      slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= '{cmd: cmd_t'(cmd), data: data};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[rtl/core/mcfce_exec.sv]
`timescale 1ns / 1ps
module mcfce_exec import mcfce_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       pop,
  output exec_stat_t stat,
  output logic       out_strobe,
  output logic [7:0] out_data,
  output logic [7:0] out_status,
  output logic       out_int
);

  localparam int CARD_BYTES = 1 << CARD_ADDR_BITS;
  localparam int PAGE_BYTES = 1 << PAGE_BITS;

  exec_state_t state_r, state_nxt;
  logic [ADDR_BITS-1:0]      addr_r, addr_nxt;
  logic [15:0]               pos_r, pos_nxt;
  logic [7:0]                op_r, op_nxt;
  logic [7:0]                stat_r, stat_nxt;
  logic [7:0]                sw_r, sw_nxt;
  logic                      pend_r, pend_nxt;
  logic [15:0]               cd_r, cd_nxt;
  logic [CARD_ADDR_BITS-1:0] cnt_r, cnt_nxt;
  logic                      sector_r, sector_nxt;
  logic [15:0]               rem_r, rem_nxt;
  logic [PAGE_BITS-1:0]      k_r, k_nxt;
  logic                      ostb_r, ostb_nxt;
  logic [7:0]                odat_r, odat_nxt;
  logic [7:0]                ost_r, ost_nxt;
  logic                      oint_r, oint_nxt;

  logic [7:0] card_mem [CARD_BYTES];
  logic [7:0] pb_mem [PAGE_BYTES];
  logic [PAGE_BYTES-1:0] pb_valid_r;
  logic [7:0] rd_data_r, pb_rd_r;
  logic       pb_rv_r;

  logic                      mem_we, mem_re;
  logic [CARD_ADDR_BITS-1:0] mem_wa, mem_ra;
  logic [7:0]                mem_wd;
  logic                      pb_we, pb_re;
  logic [PAGE_BITS-1:0]      pb_wa;

  function automatic logic [ADDR_BITS-1:0] next_in_sector(input logic [ADDR_BITS-1:0] a);
    logic [SECTOR_BITS-1:0] lo;
    lo = a[SECTOR_BITS-1:0] + 1'b1;
    return {a[ADDR_BITS-1:SECTOR_BITS], lo};
  endfunction

  // address build: bytes 1,2 always, bytes 3,4 only for array read and page program
  function automatic logic [ADDR_BITS-1:0] build_addr(input logic [ADDR_BITS-1:0] a,
                                                      input logic [15:0] p,
                                                      input logic [7:0] b,
                                                      input logic full);
    logic [ADDR_BITS-1:0] r;
    r = a;
    if (p == 16'd1)              r = {b, 17'd0};
    else if (p == 16'd2)         r = a | {8'd0, b, 9'd0};
    else if (p == 16'd3 && full) r = a | {16'd0, b[1:0], 7'd0};
    else if (p == 16'd4 && full) r = a | {18'd0, b[6:0]};
    return r;
  endfunction

  assign pop        = q_valid && (state_r == EX_IDLE);
  assign stat       = '{clearing: (state_r == EX_INIT), idle: (state_r == EX_IDLE)};
  assign out_strobe = ostb_r;
  assign out_data   = odat_r;
  assign out_status = ost_r;
  assign out_int    = oint_r;

  always_comb begin
    logic [7:0]           b;
    logic [7:0]           r;
    logic [ADDR_BITS-1:0] a;
    logic                 emit;
    logic                 fin_cmd;
    logic                 fin_later;
    logic                 last;
    logic [15:0]          n;
    state_nxt  = state_r;
    addr_nxt   = addr_r;
    pos_nxt    = pos_r;
    op_nxt     = op_r;
    stat_nxt   = stat_r;
    sw_nxt     = sw_r;
    pend_nxt   = pend_r;
    cd_nxt     = cd_r;
    cnt_nxt    = cnt_r;
    sector_nxt = sector_r;
    rem_nxt    = rem_r;
    k_nxt      = k_r;
    mem_we = 1'b0; mem_wa = '0; mem_wd = 8'hFF;
    mem_re = 1'b0; mem_ra = '0;
    pb_we  = 1'b0; pb_wa  = '0; pb_re = 1'b0;
    b = q_item.data;
    r = 8'hFF;
    a = addr_r;
    emit = 1'b0; fin_cmd = 1'b0; fin_later = 1'b0; last = 1'b0;
    n = pos_r - 16'd5;

    case (state_r)
      EX_INIT, EX_SWEEP: begin
        mem_we = 1'b1;
        if (sector_r) begin
          mem_wa = {addr_r[CARD_ADDR_BITS-1:BLOCK_BITS], cnt_r[BLOCK_BITS-1:0]};
          last   = &cnt_r[BLOCK_BITS-1:0];
        end else begin
          mem_wa = cnt_r;
          last   = &cnt_r;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          state_nxt = EX_IDLE;
          emit      = (state_r == EX_SWEEP);
        end
      end
      EX_RD_WAIT: begin
        r         = rd_data_r;
        emit      = 1'b1;
        state_nxt = EX_IDLE;
      end
      EX_PROG_RD: begin
        pb_re     = 1'b1;
        state_nxt = EX_PROG_WR;
      end
      EX_PROG_WR: begin
        mem_we   = 1'b1;
        mem_wa   = addr_r[CARD_ADDR_BITS-1:0];
        mem_wd   = pb_rv_r ? pb_rd_r : 8'h00;
        addr_nxt = next_in_sector(addr_r);
        k_nxt    = k_r + 1'b1;
        rem_nxt  = rem_r - 16'd1;
        if (rem_r == 16'd1) begin
          emit      = 1'b1;
          state_nxt = EX_IDLE;
        end else begin
          state_nxt = EX_PROG_RD;
        end
      end
      EX_IDLE: begin
        if (q_valid) begin
          case (q_item.cmd)
            CMD_SELECT: begin
              pos_nxt = 16'd0;
              emit    = 1'b1;
            end
            CMD_TICK: begin
              if (cd_r != 16'd0) begin
                cd_nxt  = cd_r - 16'd1;
                fin_cmd = (cd_r == 16'd1);
              end
              emit = 1'b1;
            end
            CMD_DESELECT: begin
              emit = 1'b1;
              case (op_r)
                OP_SECTOR_ERASE: begin
                  if (pos_r > 16'd2) begin
                    stat_nxt   = (stat_r | ST_BUSY) & ~ST_READY;
                    fin_later  = 1'b1;
                    sector_nxt = 1'b1;
                    cnt_nxt    = '0;
                    state_nxt  = EX_SWEEP;
                    emit       = 1'b0;
                  end
                end
                OP_CHIP_ERASE: begin
                  if (pos_r > 16'd2) begin
                    stat_nxt   = stat_r & ~ST_BUSY;
                    sector_nxt = 1'b0;
                    cnt_nxt    = '0;
                    state_nxt  = EX_SWEEP;
                    emit       = 1'b0;
                  end
                end
                OP_PAGE_PROGRAM: begin
                  if (pos_r >= 16'd5) begin
                    stat_nxt  = stat_r & ~ST_BUSY;
                    fin_later = 1'b1;
                    if (n != 16'd0) begin
                      rem_nxt   = n;
                      k_nxt     = '0;
                      state_nxt = EX_PROG_RD;
                      emit      = 1'b0;
                    end
                  end
                end
                default: ;
              endcase
            end
            default: begin  // byte transfer
              emit    = 1'b1;
              pos_nxt = (pos_r == 16'hFFFF) ? pos_r : pos_r + 16'd1;
              if (pos_r == 16'd0) begin
                op_nxt = b;
                if (b == OP_CLEAR_STATUS) begin
                  stat_nxt = (stat_r & ~(ST_PROG_ERR | ST_ERASE_ERR)) | ST_READY;
                  pend_nxt = 1'b0;
                end
              end else begin
                case (op_r)
                  OP_SIZE_ID: begin
                    if (pos_r == 16'd1) begin
                      r = 8'h80;
                    end else begin
                      case (n[1:0] + 2'd3)   // (p - 2) & 3
                        2'd0:    r = cfg.size_id[31:24];
                        2'd1:    r = cfg.size_id[23:16];
                        2'd2:    r = cfg.size_id[15:8];
                        default: r = cfg.size_id[7:0];
                      endcase
                    end
                  end
                  OP_READ_ARRAY: begin
                    a        = build_addr(addr_r, pos_r, b, 1'b1);
                    addr_nxt = a;
                    if (pos_r > 16'd1) begin
                      mem_re    = 1'b1;
                      mem_ra    = a[CARD_ADDR_BITS-1:0];
                      emit      = 1'b0;
                      state_nxt = EX_RD_WAIT;
                      if (pos_r >= 16'd9) addr_nxt = next_in_sector(a);
                    end
                  end
                  OP_READ_STATUS: r = stat_r;
                  OP_READ_ID: begin
                    if (pos_r == 16'd1 || !pos_r[0]) r = cfg.device_id[15:8];
                    else                             r = cfg.device_id[7:0];
                  end
                  OP_SECTOR_ERASE: addr_nxt = build_addr(addr_r, pos_r, b, 1'b0);
                  OP_SET_INT: begin
                    if (pos_r == 16'd1) sw_nxt = b;
                  end
                  OP_PAGE_PROGRAM: begin
                    addr_nxt = build_addr(addr_r, pos_r, b, 1'b1);
                    if (pos_r >= 16'd5) begin
                      pb_we = 1'b1;
                      pb_wa = n[PAGE_BITS-1:0];
                    end
                  end
                  default: ;
                endcase
              end
            end
          endcase
        end
      end
      default: state_nxt = EX_IDLE;
    endcase

    if (fin_later) begin
      if (cfg.done_delay == 16'd0) begin
        cd_nxt  = 16'd0;
        fin_cmd = 1'b1;
      end else begin
        cd_nxt = cfg.done_delay;
      end
    end
    if (fin_cmd) begin
      stat_nxt = (stat_nxt | ST_READY) & ~ST_BUSY;
      pend_nxt = 1'b1;
    end

    ostb_nxt = emit;
    odat_nxt = r;
    ost_nxt  = stat_nxt;
    oint_nxt = (sw_nxt != 8'd0) && pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= EX_INIT;
      addr_r     <= '0;
      pos_r      <= '0;
      op_r       <= '0;
      stat_r     <= ST_BUSY | ST_UNLOCKED | ST_READY;
      sw_r       <= '0;
      pend_r     <= 1'b0;
      cd_r       <= '0;
      cnt_r      <= '0;
      sector_r   <= 1'b0;
      rem_r      <= '0;
      k_r        <= '0;
      ostb_r     <= 1'b0;
      pb_valid_r <= '0;
    end else begin
      state_r  <= state_nxt;
      addr_r   <= addr_nxt;
      pos_r    <= pos_nxt;
      op_r     <= op_nxt;
      stat_r   <= stat_nxt;
      sw_r     <= sw_nxt;
      pend_r   <= pend_nxt;
      cd_r     <= cd_nxt;
      cnt_r    <= cnt_nxt;
      sector_r <= sector_nxt;
      rem_r    <= rem_nxt;
      k_r      <= k_nxt;
      ostb_r   <= ostb_nxt;
      if (pb_we) pb_valid_r[pb_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    odat_r <= odat_nxt;
    ost_r  <= ost_nxt;
    oint_r <= oint_nxt;
    if (pb_re) pb_rv_r <= pb_valid_r[k_r];
  end

  // card array
  always_ff @(posedge clk) begin
    if (mem_we) card_mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data_r <= card_mem[mem_ra];
  end

  // page buffer
  always_ff @(posedge clk) begin
    if (pb_we) pb_mem[pb_wa] <= q_item.data;
    if (pb_re) pb_rd_r <= pb_mem[k_r];
  end

endmodule
